// ===== hw/rtl/utf8_sequence_filter_defines.svh =====
// Assertion macros for the UTF-8 sequence filter.
// Both forms sample on clk; the first is masked while rst_n is low.
`ifndef UTF8_SEQUENCE_FILTER_DEFINES_SVH
`define UTF8_SEQUENCE_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
`define UTF8SF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define UTF8SF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define UTF8SF_ASSERT(lbl, prop, msg)
`define UTF8SF_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/utf8sf_pkg.sv =====
package utf8sf_pkg;

  // output queue
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned PTR_W      = 3;
  localparam int unsigned FILL_W     = 4;
  localparam int unsigned MAX_BURST  = 4;

  // byte classes
  localparam logic [7:0] LEAD_LO  = 8'd192;
  localparam logic [7:0] LEAD_END = 8'd248;

  // scalar value limits
  localparam logic [20:0] CP_SURR_LO  = 21'h00D800;
  localparam logic [20:0] CP_SURR_END = 21'h00E000;
  localparam logic [20:0] CP_MAX      = 21'h10FFFF;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_entry_t;

  typedef logic [3:0][7:0] seq_t;

  // sequence length from lead bits [5:3]; leads 248 and up are screened out before
  function automatic logic [2:0] lead_length(input logic [7:0] lead);
    logic [2:0] len;
    unique case (lead[5:3])
      3'd0, 3'd1, 3'd2, 3'd3: len = 3'd2;
      3'd4, 3'd5:             len = 3'd3;
      default:                len = 3'd4;
    endcase
    return len;
  endfunction

  function automatic logic [20:0] decode_cp(input logic [2:0] len, input seq_t seq);
    logic [20:0] cp;
    unique case (len)
      3'd2:    cp = {10'd0, seq[0][4:0], seq[1][5:0]};
      3'd3:    cp = {5'd0, seq[0][3:0], seq[1][5:0], seq[2][5:0]};
      default: cp = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
    endcase
    return cp;
  endfunction

  function automatic logic is_scalar(input logic [20:0] cp);
    return (cp < CP_SURR_LO) || ((cp >= CP_SURR_END) && (cp <= CP_MAX));
  endfunction

endpackage

// ===== hw/rtl/utf8_sequence_filter.sv =====
// Output: an ASCII beat or a valid sequence is written whole into the output queue as
// its last beat is taken; it leaves in order, out_tlast set on its final byte.
// Throughput: one input beat per cycle while the 8-entry output queue holds at most
// four beats (room for a 4-byte sequence); drains one beat per cycle if out_tready.
// Reset (rst_n low, synchronous): queue emptied, no open sequence; held bytes keep
// whatever they had, as they are only read after being written.
`include "utf8_sequence_filter_defines.svh"

module utf8_sequence_filter (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  // result channel
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast   // last
);

  localparam logic [utf8sf_pkg::FILL_W-1:0] READY_LIMIT =
    utf8sf_pkg::FILL_W'(utf8sf_pkg::FIFO_DEPTH - utf8sf_pkg::MAX_BURST);

  // sequence collection state
  logic [7:0] held_r [0:2];
  logic [1:0] bytes_held_r, bytes_held_nxt;
  logic [2:0] expected_length_r, expected_length_nxt;
  logic       hold_we;

  // output queue
  utf8sf_pkg::out_entry_t                q_r [0:utf8sf_pkg::FIFO_DEPTH-1];
  logic [utf8sf_pkg::PTR_W-1:0]          head_r, head_nxt;
  logic [utf8sf_pkg::PTR_W-1:0]          tail_r, tail_nxt;
  logic [utf8sf_pkg::FILL_W-1:0]         fill_r, fill_nxt;
  logic [2:0]                            wr_cnt;
  utf8sf_pkg::out_entry_t                wr_ent [0:utf8sf_pkg::MAX_BURST-1];
  logic [utf8sf_pkg::PTR_W-1:0]          wr_idx [0:utf8sf_pkg::MAX_BURST-1];

  logic                  in_hs, out_hs;
  logic [2:0]            seq_len;
  utf8sf_pkg::seq_t      seq;
  logic [3:0][7:0]       wr_byte;
  logic [7:0]            b;

  assign in_hs  = in_tvalid & in_tready;
  assign out_hs = out_tvalid & out_tready;
  assign b      = in_tdata;

  // ready while the queue has room for a full burst, that is, holds at most four entries
  assign in_tready  = (fill_r <= READY_LIMIT);
  assign out_tvalid = (fill_r != '0);
  assign out_tdata  = q_r[head_r].data;
  assign out_tlast  = q_r[head_r].last;

  // the sequence as it stands if this beat completes it
  assign seq_len = {1'b0, bytes_held_r} + 3'd1;
  always_comb begin
    seq[0] = held_r[0];
    seq[1] = (seq_len == 3'd2) ? b : held_r[1];
    seq[2] = (seq_len == 3'd3) ? b : held_r[2];
    seq[3] = b;
  end

  always_comb begin
    bytes_held_nxt      = bytes_held_r;
    expected_length_nxt = expected_length_r;
    hold_we             = 1'b0;
    wr_cnt              = 3'd0;
    wr_byte             = seq;
    if (in_hs) begin
      priority if (!b[7]) begin
        // ASCII: passes, any open sequence is abandoned
        bytes_held_nxt = 2'd0;
        wr_cnt         = 3'd1;
        wr_byte[0]     = b;
      end else if (bytes_held_r == 2'd0) begin
        // stray continuations and bad leads fall through and are dropped
        if (b >= utf8sf_pkg::LEAD_LO && b < utf8sf_pkg::LEAD_END) begin
          expected_length_nxt = utf8sf_pkg::lead_length(b);
          bytes_held_nxt      = 2'd1;
          hold_we             = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        // non-continuation mid-sequence: drop it and the partial
        bytes_held_nxt = 2'd0;
      end else if (seq_len < expected_length_r && bytes_held_r < 2'd3) begin
        bytes_held_nxt = bytes_held_r + 2'd1;
        hold_we        = 1'b1;
      end else begin
        bytes_held_nxt = 2'd0;
        if (utf8sf_pkg::is_scalar(utf8sf_pkg::decode_cp(seq_len, seq))) begin
          wr_cnt = seq_len;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < utf8sf_pkg::MAX_BURST; k++) begin
      wr_idx[k]      = tail_r + utf8sf_pkg::PTR_W'(k);
      wr_ent[k].data = wr_byte[k];
      wr_ent[k].last = ((3'(k) + 3'd1) == wr_cnt);
    end
  end

  assign head_nxt = head_r + utf8sf_pkg::PTR_W'(out_hs);
  assign tail_nxt = tail_r + utf8sf_pkg::PTR_W'(wr_cnt);
  assign fill_nxt = fill_r + utf8sf_pkg::FILL_W'(wr_cnt) - utf8sf_pkg::FILL_W'(out_hs);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_held_r      <= 2'd0;
      expected_length_r <= 3'd0;
      head_r            <= '0;
      tail_r            <= '0;
      fill_r            <= '0;
    end else begin
      bytes_held_r      <= bytes_held_nxt;
      expected_length_r <= expected_length_nxt;
      head_r            <= head_nxt;
      tail_r            <= tail_nxt;
      fill_r            <= fill_nxt;
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk) begin
    if (hold_we) begin
      held_r[bytes_held_r] <= b;
    end
    for (int k = 0; k < utf8sf_pkg::MAX_BURST; k++) begin
      if (3'(k) < wr_cnt) begin
        q_r[wr_idx[k]] <= wr_ent[k];
      end
    end
  end

  // checks
  `UTF8SF_ASSERT(a_fill_bound, fill_r <= utf8sf_pkg::FILL_W'(utf8sf_pkg::FIFO_DEPTH), "output queue overfilled")
  `UTF8SF_ASSERT(a_open_seq, (bytes_held_r != 2'd0) |-> (expected_length_r >= 3'd2 && 3'(bytes_held_r) < expected_length_r), "open sequence inconsistent with its length")
  `UTF8SF_ASSERT(a_ascii_push, (in_hs && !in_tdata[7]) |=> (fill_r == $past(fill_r) + 4'd1 - 4'($past(out_hs))), "ASCII beat not queued")
  `UTF8SF_ASSERT_RST(a_reset, !rst_n |=> (fill_r == '0 && bytes_held_r == 2'd0), "reset left state behind")

endmodule

// ===== dv/tb_utf8_sequence_filter.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the UTF-8 sequence filter.
// A directed table opens the run, then random text made mostly of well-formed
// sequences with random content, with ASCII, truncated sequences and raw noise
// mixed in. Every result beat is checked against an in-bench model of the
// filter. The sender bursts and the receiver stalls on its own pattern.
module tb_utf8_sequence_filter;

  localparam int N_DIRECTED     = 27;
  localparam int N_RANDOM       = 124;
  localparam int HOLD_CYCLES    = 5 * utf8sf_pkg::FIFO_DEPTH;  // long enough to fill the queue
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 1000;

  // lead byte thresholds for 3- and 4-byte sequences
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD4_LO = 8'hF0;

  // How a stimulus row is checked: against the predictor, as an echo of the
  // byte itself, or as a byte that yields nothing.
  typedef enum logic [1:0] {ROW_PRED, ROW_ECHO, ROW_DROP} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] b;
  } stim_row_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] in_byte
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [7:0] out_byte
  logic       out_tlast;           // last

  utf8_sequence_filter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Directed opening. Rows marked ROW_PRED complete a sequence whose
  // emitted bytes are left to the predictor.
  stim_row_t dir_tbl [0:N_DIRECTED-1] = '{
    '{ROW_ECHO, 8'h00},  // lowest ASCII, straight after reset
    '{ROW_ECHO, 8'h7F},  // highest ASCII
    '{ROW_DROP, 8'h80},  // stray continuation
    '{ROW_DROP, 8'hF8},  // invalid lead
    '{ROW_DROP, 8'hC0},  // lowest 2-byte lead
    '{ROW_PRED, 8'h80},  //   overlong NUL goes through, no overlong check
    '{ROW_DROP, 8'hED},  // 3-byte lead
    '{ROW_DROP, 8'hA0},
    '{ROW_DROP, 8'h80},  //   U+D800 surrogate, whole sequence discarded
    '{ROW_DROP, 8'hEF},  // highest 3-byte lead
    '{ROW_DROP, 8'hBF},
    '{ROW_PRED, 8'hBF},  //   U+FFFF
    '{ROW_DROP, 8'hF4},  // 4-byte lead
    '{ROW_DROP, 8'h90},
    '{ROW_DROP, 8'h80},
    '{ROW_DROP, 8'h80},  //   0x110000, above the scalar range
    '{ROW_DROP, 8'hF7},  // highest valid lead
    '{ROW_DROP, 8'hBF},
    '{ROW_ECHO, 8'h41},  //   ASCII mid-sequence abandons it and is passed
    '{ROW_DROP, 8'hE0},
    '{ROW_DROP, 8'h80},
    '{ROW_DROP, 8'hC2},  //   new lead mid-sequence: dropped, no new sequence
    '{ROW_DROP, 8'hA9},  //   so this one is a stray continuation
    '{ROW_DROP, 8'hF0},
    '{ROW_DROP, 8'h90},
    '{ROW_DROP, 8'h80},
    '{ROW_PRED, 8'h80}   //   U+10000, lowest 4-byte scalar
  };

  stim_row_t              stim_q [$];
  utf8sf_pkg::out_entry_t exp_q  [$];

  // predictor state, at the block's widths
  logic [7:0] seq_bytes [0:2];
  logic [1:0] seq_cnt = 2'd0;
  logic [2:0] seq_len = 3'd0;

  int err_cnt    = 0;
  int n_acc      = 0;
  int n_beats    = 0;
  int hold_seen  = 0;
  int idle_cyc   = 0;

  // Advances the filter model by one byte; when keep is set, the bytes it
  // would emit are queued as expected beats.
  function automatic void filter_byte(input logic [7:0] b, input bit keep);
    logic [20:0] cp;
    int          n;
    if (!b[7]) begin
      seq_cnt = 2'd0;
      if (keep) exp_q.push_back('{data: b, last: 1'b1});
      return;
    end
    if (seq_cnt == 2'd0) begin
      if (b < utf8sf_pkg::LEAD_LO || b >= utf8sf_pkg::LEAD_END) return;
      seq_len      = (b < LEAD3_LO) ? 3'd2 : (b < LEAD4_LO) ? 3'd3 : 3'd4;
      seq_bytes[0] = b;
      seq_cnt      = 2'd1;
      return;
    end
    if (b[7:6] != 2'b10) begin
      seq_cnt = 2'd0;
      return;
    end
    if (seq_cnt + 1 < seq_len) begin
      seq_bytes[seq_cnt] = b;
      seq_cnt            = seq_cnt + 2'd1;
      return;
    end
    // complete: held bytes plus this one
    n       = seq_cnt + 1;
    seq_cnt = 2'd0;
    case (n)
      2:       cp = 21'({seq_bytes[0][4:0], b[5:0]});
      3:       cp = 21'({seq_bytes[0][3:0], seq_bytes[1][5:0], b[5:0]});
      default: cp = {seq_bytes[0][2:0], seq_bytes[1][5:0], seq_bytes[2][5:0], b[5:0]};
    endcase
    if (!(cp < utf8sf_pkg::CP_SURR_LO ||
          (cp >= utf8sf_pkg::CP_SURR_END && cp <= utf8sf_pkg::CP_MAX))) return;
    if (!keep) return;
    for (int i = 0; i < n - 1; i++) exp_q.push_back('{data: seq_bytes[i], last: 1'b0});
    exp_q.push_back('{data: b, last: 1'b1});
  endfunction

  // Random text: mostly well-formed sequences with random payload, some of
  // them cut short, plus ASCII and raw noise over the full byte range.
  task automatic build_random_text();
    int pick;
    int len;
    int cut;
    int made;
    made = 0;
    while (made < N_RANDOM) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        stim_q.push_back('{ROW_PRED, 8'($urandom_range(0, 127))});
        made++;
      end else if (pick < 80) begin
        len = $urandom_range(2, 4);
        case (len)
          2:       stim_q.push_back('{ROW_PRED, 8'($urandom_range(8'hC0, 8'hDF))});
          3:       stim_q.push_back('{ROW_PRED, 8'($urandom_range(8'hE0, 8'hEF))});
          // mostly leads that can still give a scalar value
          default: stim_q.push_back('{ROW_PRED, ($urandom_range(0, 3) != 0) ?
                                      8'($urandom_range(8'hF0, 8'hF4)) :
                                      8'($urandom_range(8'hF0, 8'hF7))});
        endcase
        // one in eight is broken off early
        cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, len - 1) : len;
        for (int i = 1; i < cut; i++)
          stim_q.push_back('{ROW_PRED, 8'($urandom_range(8'h80, 8'hBF))});
        made += cut;
      end else begin
        stim_q.push_back('{ROW_PRED, 8'($urandom_range(0, 255))});
        made++;
      end
    end
  endtask

  // Sender: bursts of random length separated by random gaps. The predictor
  // is stepped on each accepted beat, using the values seen at the edge.
  row_kind_t cur_kind   = ROW_PRED;
  int        burst_left = 0;
  int        gap_left   = 0;

  always @(posedge clk) begin
    logic       took;
    logic       nxt_valid;
    logic [7:0] nxt_data;
    row_kind_t  nxt_kind;
    stim_row_t  row;
    took      = in_tvalid && in_tready;
    nxt_valid = in_tvalid;
    nxt_data  = in_tdata;
    nxt_kind  = cur_kind;
    if (rst_n) begin
      if (took) begin
        n_acc++;
        filter_byte(in_tdata, cur_kind == ROW_PRED);
        if (cur_kind == ROW_ECHO) exp_q.push_back('{data: in_tdata, last: 1'b1});
      end
      if (!in_tvalid || took) begin
        if (gap_left > 0) begin
          gap_left--;
          nxt_valid = 1'b0;
        end else if (stim_q.size() == 0) begin
          nxt_valid = 1'b0;
        end else begin
          row       = stim_q.pop_front();
          nxt_valid = 1'b1;
          nxt_data  = row.b;
          nxt_kind  = row.kind;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end
      end
    end
    in_tvalid <= nxt_valid;
    in_tdata  <= nxt_data;
    cur_kind  <= nxt_kind;
  end

  // Receiver: checks each beat against the oldest expectation, then picks
  // its next ready. Bits [7:6] of its cycle count rotate the stall pattern
  // between always ready, two random densities and a fixed one-in-four stall.
  // Once, after sixty input beats, it holds off long enough to back the block up.
  int rx_cyc    = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    logic                   rdy;
    utf8sf_pkg::out_entry_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_beats++;
      if (exp_q.size() == 0) begin
        $error("unexpected beat: out_tdata=%02h out_tlast=%0b", out_tdata, out_tlast);
        err_cnt++;
      end else begin
        want = exp_q.pop_front();
        if (out_tdata !== want.data) begin
          $error("out_tdata: expected %02h, got %02h", want.data, out_tdata);
          err_cnt++;
        end
        if (out_tlast !== want.last) begin
          $error("out_tlast: expected %0b, got %0b", want.last, out_tlast);
          err_cnt++;
        end
      end
    end
    rdy = 1'b0;
    if (rst_n) begin
      rx_cyc++;
      if (!hold_done && n_acc >= 60) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        hold_seen++;
      end else begin
        case (rx_cyc[7:6])
          2'd0:    rdy = 1'b1;
          2'd1:    rdy = ($urandom_range(0, 3) != 0);
          2'd2:    rdy = (rx_cyc[1:0] != 2'd0);
          default: rdy = 1'($urandom_range(0, 1));
        endcase
      end
    end
    out_tready <= rdy;
  end

  // Watchdog: too long without a beat on either side ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cyc <= 0;
      end else if (idle_cyc >= WATCHDOG_LIMIT) begin
        $display("[utf8_sequence_filter] ERROR");
        $finish;
      end else begin
        idle_cyc <= idle_cyc + 1;
      end
    end
  end

  initial begin
    for (int i = 0; i < N_DIRECTED; i++) stim_q.push_back(dir_tbl[i]);
    build_random_text();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // all bytes offered and taken, then every expected beat seen
    while (stim_q.size() != 0 || in_tvalid) @(posedge clk);
    while (exp_q.size() != 0) @(posedge clk);
    // a trailing beat with nothing expected would still be caught here
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d input bytes (%0d from the directed table) and %0d output beats,",
             n_acc, N_DIRECTED, n_beats);
    $display("including a %0d-cycle receiver hold-off with the sender still offering.",
             hold_seen);
    if (err_cnt == 0) begin
      $display("[utf8_sequence_filter] OK");
    end else begin
      $display("[utf8_sequence_filter] ERROR");
    end
    $finish;
  end

endmodule
